>>> design/r2fft_pkg.sv
// Shared constants, types, twiddle ROM and helpers for the 64-point radix-2 DIF FFT.
package r2fft_pkg;

  localparam int POINTS   = 64;
  localparam int ADDR_W   = 6;
  localparam int STAGES   = 6;
  localparam int SAMPLE_W = 16;
  localparam int BIN_W    = 23;
  localparam int DIFF_W   = 24;
  localparam int TW_W     = 16;
  localparam int PROD_W   = 40;
  localparam int ACC_W    = 42;
  localparam int HALF     = 32;
  localparam int QUARTER  = 16;
  localparam int CPX_W    = 2 * BIN_W;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] TW_MAX  = 64'd32767;

  localparam logic signed [ACC_W-1:0] BIN_MAX = ACC_W'(4194303);
  localparam logic signed [ACC_W-1:0] BIN_MIN = -ACC_W'(4194304);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(16384);

  typedef struct packed {
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
  } cpx_t;

  typedef struct packed {
    logic shift;
    logic repl;
  } cell_ctl_t;

  typedef enum logic [1:0] {ST_LOAD, ST_FFT, ST_COPY} st_t;

  // Quarter-wave sine in Q1.15 from an odd series through x^13 in Q2.30
  function automatic logic [63:0] sin_quarter(input logic [63:0] q);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x  = (64'd2 * PI_Q30 * q) / POINTS;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    r  = (s + (64'd1 << 14)) >> 15;
    if (r > TW_MAX) begin
      r = TW_MAX;
    end
    return r;
  endfunction

  // Pack {cos, sin} for k = 0 .. HALF-1, entry k at bits [k*32 +: 32]
  function automatic logic [2*TW_W*HALF-1:0] build_tw();
    logic [2*TW_W*HALF-1:0] rom;
    logic [63:0] sv;
    logic [63:0] cv;
    logic [TW_W-1:0] c16;
    logic [TW_W-1:0] s16;
    rom = '0;
    for (int k = 0; k < HALF; k++) begin
      if (k <= QUARTER) begin
        sv  = sin_quarter(64'(k));
        cv  = sin_quarter(64'(QUARTER - k));
        s16 = sv[TW_W-1:0];
        c16 = cv[TW_W-1:0];
      end else begin
        sv  = sin_quarter(64'(HALF - k));
        cv  = sin_quarter(64'(k - QUARTER));
        s16 = sv[TW_W-1:0];
        c16 = ~cv[TW_W-1:0] + 16'd1;
      end
      rom[k*2*TW_W +: 2*TW_W] = {c16, s16};
    end
    return rom;
  endfunction

  localparam logic [2*TW_W*HALF-1:0] TW_ROM = build_tw();

  function automatic logic [ADDR_W-1:0] rev_addr(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    for (int i = 0; i < ADDR_W; i++) begin
      r[i] = a[ADDR_W-1-i];
    end
    return r;
  endfunction

  function automatic logic signed [BIN_W-1:0] sat_bin(input logic signed [ACC_W-1:0] v);
    logic signed [BIN_W-1:0] r;
    if (v > BIN_MAX) begin
      r = BIN_MAX[BIN_W-1:0];
    end else if (v < BIN_MIN) begin
      r = BIN_MIN[BIN_W-1:0];
    end else begin
      r = v[BIN_W-1:0];
    end
    return r;
  endfunction

  // Round half up to Q1.15 and saturate
  function automatic logic signed [BIN_W-1:0] rnd_q15(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + RND_HALF) >>> 15;
    return sat_bin(t);
  endfunction

endpackage

>>> design/r2fft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module r2fft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/r2fft_cell.sv
// One word of the rotating work ring: takes its neighbour's word or a replacement on shift.
module r2fft_cell (
  input  logic                 clk,
  input  r2fft_pkg::cell_ctl_t ctl,
  input  r2fft_pkg::cpx_t      nbr,
  input  r2fft_pkg::cpx_t      repl_data,
  output r2fft_pkg::cpx_t      q
);

  r2fft_pkg::cpx_t q_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q_r <= ctl.repl ? repl_data : nbr;
    end
  end

  assign q = q_r;

endmodule

>>> design/radix2_dif_fft_64.sv
// Top level of the 64-point radix-2 decimation-in-frequency FFT.
// Usage:
//   Input channel in_valid / in_stall carries one Q1.15 complex sample per request.
//   Sixty-four requests form one frame; the last one starts the transform.
//   Output channel out_valid / out_stall returns 64 bins of 23 bits in natural
//   order, bin_index 0..63, with last_bin high on bin 63.
// Operation:
//   Loading accepts one sample per cycle. Each of the 6 stages rotates a ring of 64
//   cells once: each of the 32 pairs steps through the one shared multiplier, the
//   other 32 positions simply shift. A copy then writes the ring through
//   bit-reversed addresses into the result RAM; each bin then goes through a RAM
//   read, the output register and the hand-off. The next frame may load while
//   bins drain.
// Reset:
//   rst_n low clears the sample load count, the sequencer and the output side.
// Stall:
//   A stalled output holds its bin; the copy of the next frame waits until the
//   previous frame's bins have all been read out of the result RAM.
module radix2_dif_fft_64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_sample_real,
  input  logic [15:0] in_sample_imag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [22:0] out_bin_real,
  output logic [22:0] out_bin_imag,
  output logic [5:0]  out_bin_index,
  output logic        out_last_bin
);

  localparam int N   = r2fft_pkg::POINTS;
  localparam int AW  = r2fft_pkg::ADDR_W;
  localparam int BW  = r2fft_pkg::BIN_W;
  localparam int DW  = r2fft_pkg::DIFF_W;
  localparam int TW  = r2fft_pkg::TW_W;
  localparam int PW  = r2fft_pkg::PROD_W;
  localparam int CW  = r2fft_pkg::ACC_W;

  r2fft_pkg::st_t st_r, st_nxt;
  logic [AW-1:0] load_cnt_r, load_cnt_nxt;
  logic [2:0]    stage_r, stage_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [2:0]    bstep_r, bstep_nxt;

  r2fft_pkg::cpx_t cells_q [N];
  r2fft_pkg::cpx_t tap_b;
  r2fft_pkg::cpx_t sum_r, sum_nxt;
  r2fft_pkg::cpx_t newb;
  r2fft_pkg::cpx_t d63;
  r2fft_pkg::cpx_t sample;
  r2fft_pkg::cell_ctl_t cell_ctl [N];

  logic signed [DW-1:0] dr_r, dr_nxt, di_r, di_nxt;
  logic signed [TW-1:0] c_r, c_nxt, s_r, s_nxt;
  logic signed [CW-1:0] acc_r, acc_nxt;
  logic signed [BW-1:0] nbr_r, nbr_nxt;
  logic signed [DW-1:0] mul_a;
  logic signed [TW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  logic [AW-1:0] half_w;
  logic [10:0]   tw_sh;
  logic [4:0]    tw_k;
  logic [2*TW-1:0] tw_word;
  logic          bf_pair;
  logic          in_acc;
  logic          shift_all;
  logic          bf_write;
  logic          copy_en;
  logic          copy_last;
  logic          repl63;

  logic          out_busy_r;
  logic          pend_r;
  logic          out_valid_r;
  logic [AW-1:0] out_k_r;
  logic [BW-1:0] out_re_r, out_im_r;
  logic [AW-1:0] out_idx_r;
  logic          out_last_r;
  r2fft_pkg::cpx_t ram_rdata;
  r2fft_pkg::cpx_t ram_wdata;

  assign sample.re = BW'($signed(in_sample_real));
  assign sample.im = BW'($signed(in_sample_imag));

  assign in_stall = (st_r != r2fft_pkg::ST_LOAD);
  assign in_acc   = in_valid && !in_stall;

  assign half_w  = AW'(6'd32 >> stage_r);
  assign bf_pair = (pos_r & half_w) == '0;
  assign tw_sh   = {5'd0, (pos_r & (half_w - 6'd1))} << stage_r;
  assign tw_k    = tw_sh[4:0];
  assign tw_word = r2fft_pkg::TW_ROM[{tw_k, 5'd0} +: 2*TW];

  always_comb begin
    case (stage_r)
      3'd0:    tap_b = cells_q[32];
      3'd1:    tap_b = cells_q[16];
      3'd2:    tap_b = cells_q[8];
      3'd3:    tap_b = cells_q[4];
      3'd4:    tap_b = cells_q[2];
      default: tap_b = cells_q[1];
    endcase
  end

  // Shared multiplier: operands follow the butterfly step
  always_comb begin
    case (bstep_r)
      3'd1:    begin mul_a = dr_r; mul_b = c_r; end
      3'd2:    begin mul_a = di_r; mul_b = s_r; end
      3'd3:    begin mul_a = di_r; mul_b = c_r; end
      default: begin mul_a = dr_r; mul_b = s_r; end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign newb.re = nbr_r;
  assign newb.im = r2fft_pkg::rnd_q15(acc_r - CW'(prod));

  always_comb begin
    logic signed [DW-1:0] sre;
    logic signed [DW-1:0] sim;
    st_nxt       = st_r;
    load_cnt_nxt = load_cnt_r;
    stage_nxt    = stage_r;
    pos_nxt      = pos_r;
    bstep_nxt    = bstep_r;
    sum_nxt      = sum_r;
    dr_nxt       = dr_r;
    di_nxt       = di_r;
    c_nxt        = c_r;
    s_nxt        = s_r;
    acc_nxt      = acc_r;
    nbr_nxt      = nbr_r;
    shift_all    = 1'b0;
    bf_write     = 1'b0;
    copy_en      = 1'b0;
    copy_last    = 1'b0;
    sre = {cells_q[0].re[BW-1], cells_q[0].re} + {tap_b.re[BW-1], tap_b.re};
    sim = {cells_q[0].im[BW-1], cells_q[0].im} + {tap_b.im[BW-1], tap_b.im};
    case (st_r)
      r2fft_pkg::ST_LOAD: begin
        if (in_acc) begin
          shift_all    = 1'b1;
          load_cnt_nxt = load_cnt_r + 6'd1;
          if (load_cnt_r == 6'(N - 1)) begin
            st_nxt    = r2fft_pkg::ST_FFT;
            stage_nxt = '0;
            pos_nxt   = '0;
            bstep_nxt = '0;
          end
        end
      end
      r2fft_pkg::ST_FFT: begin
        case (bstep_r)
          3'd0: begin
            if (bf_pair) begin
              sum_nxt.re = r2fft_pkg::sat_bin(CW'(sre));
              sum_nxt.im = r2fft_pkg::sat_bin(CW'(sim));
              dr_nxt = {cells_q[0].re[BW-1], cells_q[0].re} - {tap_b.re[BW-1], tap_b.re};
              di_nxt = {cells_q[0].im[BW-1], cells_q[0].im} - {tap_b.im[BW-1], tap_b.im};
              c_nxt  = tw_word[2*TW-1:TW];
              s_nxt  = tw_word[TW-1:0];
              bstep_nxt = 3'd1;
            end else begin
              shift_all = 1'b1;
            end
          end
          3'd1: begin
            acc_nxt   = CW'(prod);
            bstep_nxt = 3'd2;
          end
          3'd2: begin
            nbr_nxt   = r2fft_pkg::rnd_q15(acc_r + CW'(prod));
            bstep_nxt = 3'd3;
          end
          3'd3: begin
            acc_nxt   = CW'(prod);
            bstep_nxt = 3'd4;
          end
          default: begin
            bf_write  = 1'b1;
            shift_all = 1'b1;
            bstep_nxt = 3'd0;
          end
        endcase
        if (shift_all) begin
          pos_nxt = pos_r + 6'd1;
          if (pos_r == 6'(N - 1)) begin
            if (stage_r == 3'(r2fft_pkg::STAGES - 1)) begin
              stage_nxt = '0;
              st_nxt    = r2fft_pkg::ST_COPY;
            end else begin
              stage_nxt = stage_r + 3'd1;
            end
          end
        end
      end
      r2fft_pkg::ST_COPY: begin
        if (!out_busy_r) begin
          copy_en   = 1'b1;
          shift_all = 1'b1;
          pos_nxt   = pos_r + 6'd1;
          if (pos_r == 6'(N - 1)) begin
            copy_last = 1'b1;
            st_nxt    = r2fft_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        st_nxt = r2fft_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= r2fft_pkg::ST_LOAD;
      load_cnt_r <= '0;
      stage_r    <= '0;
      pos_r      <= '0;
      bstep_r    <= '0;
    end else begin
      st_r       <= st_nxt;
      load_cnt_r <= load_cnt_nxt;
      stage_r    <= stage_nxt;
      pos_r      <= pos_nxt;
      bstep_r    <= bstep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    dr_r  <= dr_nxt;
    di_r  <= di_nxt;
    c_r   <= c_nxt;
    s_r   <= s_nxt;
    acc_r <= acc_nxt;
    nbr_r <= nbr_nxt;
  end

  // Ring: cell i takes cell i+1 or the new b; the last takes cell 0, sample or sum
  assign repl63 = in_acc || bf_write;
  assign d63    = in_acc ? sample : sum_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign cell_ctl[i].shift = shift_all;
    if (i == N - 1) begin : g_last
      assign cell_ctl[i].repl = repl63;
      r2fft_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[i]),
        .nbr       (cells_q[0]),
        .repl_data (d63),
        .q         (cells_q[i])
      );
    end else begin : g_mid
      assign cell_ctl[i].repl = bf_write && (half_w == AW'(i + 1));
      r2fft_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[i]),
        .nbr       (cells_q[i+1]),
        .repl_data (newb),
        .q         (cells_q[i])
      );
    end
  end

  assign ram_wdata = cells_q[0];

  r2fft_ram #(
    .WIDTH (r2fft_pkg::CPX_W),
    .DEPTH (N)
  ) u_ram (
    .clk   (clk),
    .we    (copy_en),
    .waddr (r2fft_pkg::rev_addr(pos_r)),
    .wdata (ram_wdata),
    .raddr (out_k_r),
    .rdata (ram_rdata)
  );

  // Output side: read the bin, then load the output register when it is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_busy_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_k_r     <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (copy_last) begin
        out_busy_r <= 1'b1;
        out_k_r    <= '0;
      end else if (pend_r) begin
        pend_r      <= 1'b0;
        out_valid_r <= 1'b1;
        out_k_r     <= out_k_r + 6'd1;
        if (out_k_r == 6'(N - 1)) begin
          out_busy_r <= 1'b0;
        end
      end else if (out_busy_r && !out_valid_r) begin
        pend_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      out_re_r   <= ram_rdata.re;
      out_im_r   <= ram_rdata.im;
      out_idx_r  <= out_k_r;
      out_last_r <= (out_k_r == 6'(N - 1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_real  = out_re_r;
  assign out_bin_imag  = out_im_r;
  assign out_bin_index = out_idx_r;
  assign out_last_bin  = out_last_r;

`ifndef NO_ASSERTIONS
  a_rise_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend_r))
    else $error("output became valid without a RAM read");
  a_busy_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_busy_r) |-> $past(st_r == r2fft_pkg::ST_COPY))
    else $error("output drain started outside the copy");
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_idx_r == 6'(N - 1)))
    else $error("last bin flag on a bin other than the final one");
  a_bstep_fft: assert property (@(posedge clk) disable iff (!rst_n)
    (bstep_r != 3'd0) |-> (st_r == r2fft_pkg::ST_FFT))
    else $error("butterfly step outside the transform");
`endif

endmodule

>>> dv/fft_checker.sv
// Checker for the 64-point FFT: predicts bins from accepted samples and compares them.
`timescale 1ns / 1ps
module fft_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_sample_real,
  input  logic [15:0] in_sample_imag,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [22:0] out_bin_real,
  input  logic [22:0] out_bin_imag,
  input  logic [5:0]  out_bin_index,
  input  logic        out_last_bin,
  output int          fail_count,
  output int          pending_bins,
  output int          bins_seen
);

  typedef struct {
    logic [22:0] re;
    logic [22:0] im;
    logic [5:0]  idx;
    logic        last;
  } bin_t;

  bin_t        bin_queue[$];
  longint      frame_re[64];
  longint      frame_im[64];
  int          fill;
  longint      cos_tab[32];
  longint      sin_tab[32];

  function automatic longint quarter_sine(longint unsigned q);
    longint unsigned x, x2, t, s, r;
    longint unsigned dv[6];
    dv = '{156, 110, 72, 42, 20, 6};
    x  = (2 * 64'd3373259426 * q) / 64;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    for (int i = 0; i < 6; i++) t = (64'd1 << 30) - (((x2 * t) >> 30) / dv[i]);
    s = (x * t) >> 30;
    r = (s + (64'd1 << 14)) >> 15;
    if (r > 32767) r = 32767;
    return longint'(r);
  endfunction

  function automatic longint clamp_bin(longint v);
    if (v > 4194303) return 4194303;
    if (v < -4194304) return -4194304;
    return v;
  endfunction

  function automatic longint round_half_up(longint v);
    return (v + 16384) >>> 15;
  endfunction

  initial begin
    for (int k = 0; k < 32; k++) begin
      if (k <= 16) begin
        sin_tab[k] = quarter_sine(k);
        cos_tab[k] = quarter_sine(16 - k);
      end else begin
        sin_tab[k] = quarter_sine(32 - k);
        cos_tab[k] = -quarter_sine(k - 16);
      end
    end
  end

  task automatic transform_frame();
    longint ar, ai, br, bi, dr, di, c, s;
    int p, q, tw, r;
    bin_t b;
    for (int m = 64; m > 1; m /= 2) begin
      for (int i = 0; i < 64 / m; i++) begin
        for (int j = 0; j < m / 2; j++) begin
          p = i * m + j;
          q = p + m / 2;
          tw = j * (64 / m);
          ar = frame_re[p]; ai = frame_im[p];
          br = frame_re[q]; bi = frame_im[q];
          dr = ar - br; di = ai - bi;
          c = cos_tab[tw]; s = sin_tab[tw];
          frame_re[p] = clamp_bin(ar + br);
          frame_im[p] = clamp_bin(ai + bi);
          frame_re[q] = clamp_bin(round_half_up(dr * c + di * s));
          frame_im[q] = clamp_bin(round_half_up(di * c - dr * s));
        end
      end
    end
    for (int k = 0; k < 64; k++) begin
      r = 0;
      for (int i = 0; i < 6; i++) r = (r << 1) | ((k >> i) & 1);
      b.re = frame_re[r][22:0];
      b.im = frame_im[r][22:0];
      b.idx = k[5:0];
      b.last = (k == 63);
      bin_queue.push_back(b);
    end
  endtask

  always @(posedge clk) begin
    bin_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fill <= 0;
      fail_count <= 0;
      bins_seen <= 0;
      pending_bins <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        frame_re[fill] = longint'($signed(in_sample_real));
        frame_im[fill] = longint'($signed(in_sample_imag));
        if (fill == 63) begin
          transform_frame();
          fill <= 0;
        end else begin
          fill <= fill + 1;
        end
      end
      if (out_valid && !out_stall) begin
        bins_seen <= bins_seen + 1;
        if (bin_queue.size() == 0) begin
          $error("unexpected bin %0d", out_bin_index);
          errs++;
        end else begin
          e = bin_queue.pop_front();
          if (out_bin_real !== e.re) begin
            $error("bin_real: expected %h, got %h", e.re, out_bin_real);
            errs++;
          end
          if (out_bin_imag !== e.im) begin
            $error("bin_imag: expected %h, got %h", e.im, out_bin_imag);
            errs++;
          end
          if (out_bin_index !== e.idx) begin
            $error("bin_index: expected %0d, got %0d", e.idx, out_bin_index);
            errs++;
          end
          if (out_last_bin !== e.last) begin
            $error("last_bin: expected %0d, got %0d", e.last, out_last_bin);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_bins <= bin_queue.size();
    end
  end
endmodule

>>> dv/testbench.sv
// Stimulus and verdict for the 64-point FFT: drives sample frames under random flow control.
`timescale 1ns / 1ps
module testbench;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [15:0] in_sample_real = '0;
  logic [15:0] in_sample_imag = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [22:0] out_bin_real, out_bin_imag;
  logic [5:0]  out_bin_index;
  logic        out_last_bin;
  int          fail_count, pending_bins, bins_seen;
  int          sent;
  longint      cycles;
  bit          hold_off;

  localparam int FRAMES = 3;
  localparam longint CYCLE_LIMIT = 400000;

  always #1 clk = ~clk;

  radix2_dif_fft_64 dut (.*);

  fft_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stall pattern, plus one long hold-off
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1;
    else if ($urandom_range(0, 3) == 0) out_stall <= ($urandom_range(0, 2) != 0);
    else out_stall <= 0;
  end

  // sample for frame f, index n: directed extremes in frame 0, all-minimum in frame 1, random later
  function automatic logic [31:0] pick_sample(int f, int n);
    logic [15:0] re, im;
    if (f == 0) begin
      case (n % 8)
        0: begin re = 16'h7fff; im = 16'h7fff; end
        1: begin re = 16'h8000; im = 16'h8000; end
        2: begin re = 16'h7fff; im = 16'h8000; end
        3: begin re = 16'h8000; im = 16'h7fff; end
        4: begin re = 16'h0000; im = 16'hffff; end
        5: begin re = 16'h0001; im = 16'h0000; end
        default: begin re = 16'h7fff; im = 16'h0000; end
      endcase
    end else if (f == 1 && n < 64) begin
      re = 16'h8000; im = 16'h8000; // all-minimum frame, full growth
    end else begin
      re = 16'($urandom); im = 16'($urandom);
    end
    return {re, im};
  endfunction

  task automatic send_frame(int f);
    logic [31:0] smp;
    int burst;
    int gap;
    burst = 0;
    for (int n = 0; n < 64; n++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
          in_valid <= 0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 20);
      end
      smp = pick_sample(f, n);
      in_valid <= 1;
      in_sample_real <= smp[31:16];
      in_sample_imag <= smp[15:0];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      burst--;
      sent++;
    end
    in_valid <= 0;
    @(posedge clk);
  endtask

  initial begin
    cycles = 0;
    sent = 0;
    hold_off = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int f = 0; f < FRAMES; f++) begin
      if (f == 1) begin
        // hold the receiver off while further frames arrive
        fork
          begin
            hold_off = 1;
            repeat (4000) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      send_frame(f);
    end
    while (pending_bins != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d samples in %0d frames, checked %0d bins", sent, FRAMES, bins_seen);
    $display("frames covered full-scale extremes, minimum-value growth and random data");
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
